FILE: rtl/core/lfu_pkg.sv
// package for the lfu cache table: sizes, word types and the control store
package lfu_pkg;

  // sizes
  localparam int ENTRIES    = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LIVE_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int CMP_W      = (LIVE_W > CAP_W) ? LIVE_W : CAP_W;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int STAMP_BITS = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic             OP_GET     = 1'b0;
  localparam logic             OP_PUT     = 1'b1;

  // input word
  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // result word
  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  // control store addresses
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CAP,
    STEP_SCAN,
    STEP_DECIDE,
    STEP_INSERT,
    STEP_HIT,
    STEP_EMIT
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_CAP_ZERO,
    COND_LAST,
    COND_FOUND,
    COND_OUT_BUSY
  } cond_t;

  // datapath controls of one step
  typedef struct packed {
    logic accept;
    logic scan;
    logic hit_wr;
    logic insert;
    logic emit;
  } ctrl_t;

  // flags that the datapath returns to the sequencer
  typedef struct packed {
    logic in_valid;
    logic cap_zero;
    logic last;
    logic found;
    logic out_busy;
  } status_t;

  // one control word: jump to target when cond holds, else go to seq
  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t target;
    step_t seq;
  } ucode_t;

  // the microprogram
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    w = '{ctrl: '0, cond: COND_ALWAYS, target: STEP_IDLE, seq: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.ctrl.accept = 1'b1;
        w.cond        = COND_IN_VALID;
        w.target      = STEP_CAP;
        w.seq         = STEP_IDLE;
      end
      STEP_CAP: begin
        w.cond   = COND_CAP_ZERO;
        w.target = STEP_EMIT;
        w.seq    = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.ctrl.scan = 1'b1;
        w.cond      = COND_LAST;
        w.target    = STEP_DECIDE;
        w.seq       = STEP_SCAN;
      end
      STEP_DECIDE: begin
        w.cond   = COND_FOUND;
        w.target = STEP_HIT;
        w.seq    = STEP_INSERT;
      end
      STEP_INSERT: begin
        w.ctrl.insert = 1'b1;
        w.cond        = COND_ALWAYS;
        w.target      = STEP_EMIT;
        w.seq         = STEP_EMIT;
      end
      STEP_HIT: begin
        w.ctrl.hit_wr = 1'b1;
        w.cond        = COND_ALWAYS;
        w.target      = STEP_EMIT;
        w.seq         = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.target    = STEP_EMIT;
        w.seq       = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
        w.seq    = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/lfu_seq.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
module lfu_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  lfu_pkg::status_t status,
  output lfu_pkg::ctrl_t   ctrl
);
  import lfu_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  ucode_t uw;
  logic   take;

  // control word of the current step
  assign uw   = ucode_rom(pc_r);
  assign ctrl = uw.ctrl;

  // jump condition select
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_IN_VALID: take = status.in_valid;
      COND_CAP_ZERO: take = status.cap_zero;
      COND_LAST:     take = status.last;
      COND_FOUND:    take = status.found;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
  end

  assign pc_nxt = take ? uw.target : uw.seq;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/core/lfu_dpath.sv
// datapath: entry table, scan accumulators, capacity register and result register
module lfu_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfu_pkg::ctrl_t              ctrl,
  output lfu_pkg::status_t            status,
  input  logic                        in_valid,
  input  lfu_pkg::req_t               in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lfu_pkg::rsp_t               out_word,
  input  logic                        cfg_wr_en,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_wr_data
);
  import lfu_pkg::*;

  // entry table, read only at the scan index
  logic [ENTRIES-1:0]    ent_vld_r;
  logic [KEY_W-1:0]      ent_key_r   [ENTRIES];
  logic [VAL_W-1:0]      ent_val_r   [ENTRIES];
  logic [COUNT_W-1:0]    ent_cnt_r   [ENTRIES];
  logic [STAMP_BITS-1:0] ent_stamp_r [ENTRIES];
  logic [STAMP_BITS-1:0] touch_r;

  logic [CAP_W-1:0]      cap_r;
  req_t                  req_r;
  logic [IDX_W-1:0]      idx_r;

  // scan accumulators
  logic                  found_r;
  logic [IDX_W-1:0]      found_idx_r;
  logic [VAL_W-1:0]      found_val_r;
  logic [COUNT_W-1:0]    found_cnt_r;
  logic [LIVE_W-1:0]     live_r;
  logic                  vic_vld_r;
  logic [IDX_W-1:0]      vic_idx_r;
  logic [COUNT_W-1:0]    vic_cnt_r;
  logic [STAMP_BITS-1:0] vic_stamp_r;
  logic                  free_vld_r;
  logic [IDX_W-1:0]      free_idx_r;

  logic                  out_valid_r;
  rsp_t                  out_word_r;

  logic                  accept;
  logic                  out_busy;
  logic                  emit_fire;
  logic                  rd_vld;
  logic [KEY_W-1:0]      rd_key;
  logic [VAL_W-1:0]      rd_val;
  logic [COUNT_W-1:0]    rd_cnt;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_match;
  logic                  rd_better;
  logic [CMP_W-1:0]      cap_eff;
  logic                  evict;
  logic                  use_vic;
  logic                  kill_vic;
  logic [IDX_W-1:0]      ins_slot;
  logic                  do_insert;
  logic                  do_hit;
  logic [COUNT_W-1:0]    cnt_inc;
  rsp_t                  rsp;

  assign accept    = ctrl.accept & in_valid;
  assign out_busy  = out_valid_r & out_stall;
  assign emit_fire = ctrl.emit & ~out_busy;

  // entry at the scan index
  assign rd_vld   = ent_vld_r[idx_r];
  assign rd_key   = ent_key_r[idx_r];
  assign rd_val   = ent_val_r[idx_r];
  assign rd_cnt   = ent_cnt_r[idx_r];
  assign rd_stamp = ent_stamp_r[idx_r];
  assign rd_match = rd_vld & (rd_key == req_r.key);
  assign rd_better = ~vic_vld_r | (rd_cnt < vic_cnt_r) |
                     ((rd_cnt == vic_cnt_r) & (rd_stamp < vic_stamp_r));

  // capacity clamped to the table size
  assign cap_eff = (CMP_W'(cap_r) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_r);

  // insert slot: lowest free slot once the victim is gone
  assign evict    = CMP_W'(live_r) >= cap_eff;
  assign use_vic  = evict & (~free_vld_r | (vic_idx_r < free_idx_r));
  assign kill_vic = evict & ~use_vic;
  assign ins_slot = use_vic ? vic_idx_r : free_idx_r;

  assign do_insert = ctrl.insert & (req_r.op == OP_PUT);
  assign do_hit    = ctrl.hit_wr;
  assign cnt_inc   = (found_cnt_r == '1) ? found_cnt_r : found_cnt_r + COUNT_W'(1);

  // result of the current item
  always_comb begin
    rsp.hit = found_r;
    if (req_r.op == OP_PUT) begin
      rsp.read_value = req_r.value;
    end else if (found_r) begin
      rsp.read_value = found_val_r;
    end else begin
      rsp.read_value = MISS_VALUE;
    end
  end

  assign status.in_valid = in_valid;
  assign status.cap_zero = (cap_r == '0);
  assign status.last     = (idx_r == IDX_W'(ENTRIES - 1));
  assign status.found    = found_r;
  assign status.out_busy = out_busy;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // control state: valid marks, stamp, capacity, result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r   <= '0;
      touch_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (do_insert) begin
        if (kill_vic) begin
          ent_vld_r[vic_idx_r] <= 1'b0;
        end
        ent_vld_r[ins_slot] <= 1'b1;
      end
      if (do_insert | do_hit) begin
        touch_r <= touch_r + STAMP_BITS'(1);
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r & ~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // entry payload writes
  always_ff @(posedge clk) begin
    if (do_hit) begin
      if (req_r.op == OP_PUT) begin
        ent_val_r[found_idx_r] <= req_r.value;
      end
      ent_cnt_r[found_idx_r]   <= cnt_inc;
      ent_stamp_r[found_idx_r] <= touch_r;
    end
    if (do_insert) begin
      ent_key_r[ins_slot]   <= req_r.key;
      ent_val_r[ins_slot]   <= req_r.value;
      ent_cnt_r[ins_slot]   <= COUNT_W'(1);
      ent_stamp_r[ins_slot] <= touch_r;
    end
  end

  // request capture, scan index and accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_word;
      idx_r      <= '0;
      found_r    <= 1'b0;
      live_r     <= '0;
      vic_vld_r  <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (ctrl.scan) begin
      idx_r <= idx_r + IDX_W'(1);
      if (rd_vld) begin
        live_r <= live_r + LIVE_W'(1);
        if (rd_better) begin
          vic_vld_r   <= 1'b1;
          vic_idx_r   <= idx_r;
          vic_cnt_r   <= rd_cnt;
          vic_stamp_r <= rd_stamp;
        end
      end else if (!free_vld_r) begin
        free_vld_r <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (rd_match & ~found_r) begin
        found_r     <= 1'b1;
        found_idx_r <= idx_r;
        found_val_r <= rd_val;
        found_cnt_r <= rd_cnt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_word_r <= rsp;
    end
  end

endmodule

FILE: rtl/core/lfu_cache_table_top.sv
// top level of the lfu cache table: sequencer plus datapath
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_word  (op, key, value)
//  out     | output    | out_valid/out_stall| out_word (hit, read_value)
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (capacity_in_use)
//
// an item passes the steps idle (take the word), capacity check, a scan step for
// each entry, decision, table update (hit write or put insert) and result load;
// with capacity zero it goes from the capacity check straight to the result load.
// the scan walks the table one entry per cycle through a single read index.
// reset is synchronous; it clears the valid marks, the touch stamp and sets
// capacity to 16. a stalled result holds the sequencer in its last step.
module lfu_cache_table_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lfu_pkg::req_t             in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lfu_pkg::rsp_t             out_word,
  input  logic                      cfg_wr_en,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data
);
  import lfu_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // input is taken only in the idle step
  assign in_stall = ~ctrl.accept;

  // control
  lfu_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // datapath
  lfu_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .status      (status),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

FILE: rtl/core/lfu_chk.sv
// port checker for the lfu cache table and its bind
module lfu_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input lfu_pkg::req_t             in_word,
  input logic                      out_valid,
  input logic                      out_stall,
  input lfu_pkg::rsp_t             out_word
);
  import lfu_pkg::*;

  logic in_take;
  logic out_take;

  assign in_take  = in_valid & ~in_stall;
  assign out_take = out_valid & ~out_stall;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // one word at a time: busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input taken twice in a row");

  // still busy in the step after the capacity check (scan or result load)
  a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##2 in_stall)
    else $error("input free too early after a word");

  // handshake outputs are never unknown out of reset, nor is a result word as it is taken
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_stall, out_valid}) && (!out_take || !$isunknown(out_word)))
    else $error("unknown value on the result side");

  // a result never appears right as a word is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !$rose(out_valid))
    else $error("result appeared before the scan");

endmodule

bind lfu_cache_table_top lfu_chk u_lfu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
